// ----- rtl/weighted_moment_statistics_macros.svh -----
// ----------------------------------------------------------------------------
// Weighted moment statistics: assertion macros
// Shared property shorthands for the checker.
// ----------------------------------------------------------------------------
`ifndef WEIGHTED_MOMENT_STATISTICS_MACROS_SVH
`define WEIGHTED_MOMENT_STATISTICS_MACROS_SVH

// same-cycle implication
`define WMS_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("wms assertion failed");

// next-cycle implication
`define WMS_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("wms assertion failed");

`endif

// ----- rtl/wms_pkg.sv -----
// ----------------------------------------------------------------------------
// Weighted moment statistics package
// Shared constants and unit status type.
// ----------------------------------------------------------------------------
package wms_pkg;
    localparam int SAMPLE_BITS_DEF      = 24;
    localparam int WEIGHT_FRAC_BITS_DEF = 16;
    localparam int ACC_FRAC_BITS_DEF    = 40;
    localparam int OUT_FRAC             = 24;
    localparam int RES_W                = 32;
    localparam int PROD_W               = 128;
    localparam int OPND_W               = 64;
    localparam int ADDR_W               = 3;
    localparam logic REG_CENTER         = 1'b0;

    typedef struct packed {
        logic busy;
        logic done;
    } wms_unit_stat_t;
endpackage

// ----- rtl/wms_mul.sv -----
// ----------------------------------------------------------------------------
// wms_mul
// 64x64 unsigned multiplier built from four 32x32 partial products.
// ----------------------------------------------------------------------------
module wms_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [wms_pkg::OPND_W-1:0]    a,
    input  logic [wms_pkg::OPND_W-1:0]    b,
    output logic [wms_pkg::PROD_W-1:0]    p,
    output wms_pkg::wms_unit_stat_t       stat
);
    import wms_pkg::*;

    localparam int HW = OPND_W / 2;

    logic [OPND_W-1:0] a_reg, b_reg;
    logic [OPND_W-1:0] pp_reg;
    logic [6:0]        pp_sh_reg;
    logic [PROD_W-1:0] acc_reg;
    logic [2:0]        step_reg;
    logic              run_reg, done_reg;
    logic [HW-1:0]     op_a, op_b;
    logic [6:0]        sh_now;

    // step 0: lo*lo, 1: lo*hi, 2: hi*lo, 3: hi*hi
    always_comb begin
        op_a   = step_reg[1] ? a_reg[OPND_W-1:HW] : a_reg[HW-1:0];
        op_b   = step_reg[0] ? b_reg[OPND_W-1:HW] : b_reg[HW-1:0];
        sh_now = {step_reg[1] & step_reg[0], step_reg[1] ^ step_reg[0], 5'b0};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                a_reg    <= a;
                b_reg    <= b;
                acc_reg  <= '0;
                step_reg <= '0;
                run_reg  <= 1'b1;
            end else if (run_reg) begin
                if (step_reg != 3'd0) begin
                    acc_reg <= acc_reg + (PROD_W'(pp_reg) << pp_sh_reg);
                end
                if (step_reg == 3'd4) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    pp_reg    <= op_a * op_b;
                    pp_sh_reg <= sh_now;
                    step_reg  <= step_reg + 3'd1;
                end
            end
        end
    end

    assign p         = acc_reg;
    assign stat.busy = run_reg;
    assign stat.done = done_reg;
endmodule

// ----- rtl/wms_div.sv -----
// ----------------------------------------------------------------------------
// wms_div
// Restoring 128-bit unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wms_div (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [wms_pkg::PROD_W-1:0]    n,
    input  logic [wms_pkg::PROD_W-1:0]    d,
    output logic [wms_pkg::PROD_W-1:0]    q,
    output wms_pkg::wms_unit_stat_t       stat
);
    import wms_pkg::*;

    localparam int CW = $clog2(PROD_W);

    logic [PROD_W-1:0] n_reg, d_reg, r_reg, q_reg;
    logic [CW-1:0]     cnt_reg;
    logic              run_reg, done_reg;
    logic [PROD_W-1:0] r_sh;
    logic              ge;

    always_comb begin
        r_sh = {r_reg[PROD_W-2:0], n_reg[PROD_W-1]};
        ge   = r_sh >= d_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                n_reg   <= n;
                d_reg   <= d;
                r_reg   <= '0;
                q_reg   <= '0;
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                n_reg   <= {n_reg[PROD_W-2:0], 1'b0};
                r_reg   <= ge ? r_sh - d_reg : r_sh;
                q_reg   <= {q_reg[PROD_W-2:0], ge};
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(PROD_W - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign q         = q_reg;
    assign stat.busy = run_reg;
    assign stat.done = done_reg;
endmodule

// ----- rtl/wms_sqrt.sv -----
// ----------------------------------------------------------------------------
// wms_sqrt
// Digit-by-digit integer square root of a 64-bit value, one digit per cycle.
// ----------------------------------------------------------------------------
module wms_sqrt (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [wms_pkg::OPND_W-1:0]    x,
    output logic [wms_pkg::RES_W-1:0]     root,
    output wms_pkg::wms_unit_stat_t       stat
);
    import wms_pkg::*;

    localparam int CW = $clog2(OPND_W / 2);

    logic [OPND_W-1:0] x_reg, r_reg, b_reg;
    logic [CW-1:0]     cnt_reg;
    logic              run_reg, done_reg;
    logic [OPND_W-1:0] rb;

    assign rb = r_reg + b_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                x_reg   <= x;
                r_reg   <= '0;
                b_reg   <= OPND_W'(1) << (OPND_W - 2);
                cnt_reg <= '0;
                run_reg <= 1'b1;
            end else if (run_reg) begin
                if (x_reg >= rb) begin
                    x_reg <= x_reg - rb;
                    r_reg <= (r_reg >> 1) + b_reg;
                end else begin
                    r_reg <= r_reg >> 1;
                end
                b_reg   <= b_reg >> 2;
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(OPND_W / 2 - 1)) begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign root      = r_reg[RES_W-1:0];
    assign stat.busy = run_reg;
    assign stat.done = done_reg;
endmodule

// ----- rtl/weighted_moment_statistics.sv -----
// An item without last is accepted in S_IDLE, then runs seven products on the
// shared 64x64 multiplier, each started and awaited in turn.
// An item with last adds three divides, a square root, two more products and
// an output step; when the variance is zero only the mean divide and root run.
// Throughput: one item at a time; s_ready is high only while idle.
// Reset (synchronous, active low) clears center, accumulators and flags.
// ----------------------------------------------------------------------------
// weighted_moment_statistics
// Weighted mean, variance, std dev, skewness and kurtosis over a run of items.
// ----------------------------------------------------------------------------
module weighted_moment_statistics #(
    parameter int SAMPLE_BITS      = wms_pkg::SAMPLE_BITS_DEF,
    parameter int WEIGHT_FRAC_BITS = wms_pkg::WEIGHT_FRAC_BITS_DEF,
    parameter int ACC_FRAC_BITS    = wms_pkg::ACC_FRAC_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [wms_pkg::ADDR_W-1:0]          paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic signed [SAMPLE_BITS-1:0]       s_sample,
    input  logic [WEIGHT_FRAC_BITS:0]           s_weight,
    input  logic                                s_last,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [SAMPLE_BITS-1:0]       m_mean_out,
    output logic [wms_pkg::RES_W-1:0]           m_variance,
    output logic [wms_pkg::RES_W-1:0]           m_std_dev,
    output logic signed [wms_pkg::RES_W-1:0]    m_skewness,
    output logic signed [wms_pkg::RES_W-1:0]    m_excess_kurtosis,
    output logic                                m_zero_weight_sum,
    output logic                                m_zero_spread,
    output logic                                m_saturated
);
    import wms_pkg::*;

    localparam int SB     = SAMPLE_BITS;
    localparam int WF     = WEIGHT_FRAC_BITS;
    localparam int AF     = ACC_FRAC_BITS;
    localparam int WT_W   = 40;
    localparam int ACC_SH = AF - (SB - 1);
    localparam int ACC_L  = (ACC_SH >= 0) ? ACC_SH : 0;
    localparam int ACC_R  = (ACC_SH >= 0) ? 0 : -ACC_SH;
    localparam int E_NZ   = WF + SB - 1 - AF;
    localparam int E_Z    = SB - 1 - AF;
    localparam int NL_NZ  = (E_NZ >= 0) ? E_NZ : 0;
    localparam int DL_NZ  = (E_NZ >= 0) ? 0 : -E_NZ;
    localparam int NL_Z   = (E_Z >= 0) ? E_Z : 0;
    localparam int DL_Z   = (E_Z >= 0) ? 0 : -E_Z;
    localparam int V_SH   = AF - OUT_FRAC;
    localparam int M_SH   = 3 * OUT_FRAC - AF;
    localparam logic signed [OPND_W-1:0] S64_MAX = {1'b0, {(OPND_W-1){1'b1}}};
    localparam logic signed [OPND_W-1:0] S64_MIN = {1'b1, {(OPND_W-1){1'b0}}};
    localparam logic signed [RES_W+9:0]  KURT_OFS = (RES_W+10)'(3) <<< OUT_FRAC;
    localparam logic signed [RES_W+9:0]  KURT_TOP = (RES_W+10)'({(RES_W-1){1'b1}});

    typedef enum logic [3:0] {
        S_IDLE, S_M2, S_M3, S_M4, S_WS, S_T2, S_T3, S_T4,
        S_MEAN, S_SQRT, S_SKM, S_SKD, S_KUM, S_KUD, S_DONE
    } state_t;

    function automatic logic [OPND_W:0] sat_add(input logic signed [OPND_W-1:0] x,
                                                input logic signed [OPND_W-1:0] y);
        logic signed [OPND_W:0] s;
        s = {x[OPND_W-1], x} + {y[OPND_W-1], y};
        if (s > $signed({S64_MAX[OPND_W-1], S64_MAX})) return {1'b1, S64_MAX};
        if (s < $signed({S64_MIN[OPND_W-1], S64_MIN})) return {1'b1, S64_MIN};
        return {1'b0, s[OPND_W-1:0]};
    endfunction

    function automatic logic [OPND_W:0] clamp_mag(input logic [PROD_W-1:0] x);
        if (x[PROD_W-1:OPND_W-1] != '0) return {1'b1, S64_MAX};
        return {1'b0, x[OPND_W-1:0]};
    endfunction

    function automatic logic signed [OPND_W-1:0] signed_of(input logic [OPND_W-1:0] m,
                                                           input logic neg);
        return neg ? -$signed(m) : $signed(m);
    endfunction

    state_t state_reg;
    logic              issued_reg;
    logic [SB-1:0]     center_reg;
    logic [WT_W-1:0]   wtot_reg;
    logic signed [OPND_W-1:0] wsum_reg, mom2_reg, mom3_reg, mom4_reg;
    logic              ovf_reg, rsat_reg;
    logic [OPND_W-1:0] ms_reg, md_reg, m2_reg, m3_reg, m4_reg;
    logic              ns_reg, nd_reg, last_reg;
    logic [WF:0]       w_reg;
    logic [RES_W-1:0]  v_reg, sd_reg;
    logic [SB-1:0]     mean_reg;
    logic [RES_W-1:0]  skew_reg, kurt_reg;
    logic              zw_reg;

    logic              mul_start_reg, div_start_reg, sqrt_start_reg;
    logic [OPND_W-1:0] mul_a_reg, mul_b_reg;
    logic [PROD_W-1:0] div_n_reg, div_d_reg;
    logic [OPND_W-1:0] sqrt_x_reg;
    logic [PROD_W-1:0] mul_p, div_q;
    logic [RES_W-1:0]  sqrt_r;
    wms_unit_stat_t    mul_stat, div_stat, sqrt_stat;

    logic              m_valid_reg;
    logic [SB-1:0]     o_mean_reg;
    logic [RES_W-1:0]  o_var_reg, o_sd_reg, o_skew_reg, o_kurt_reg;
    logic              o_zw_reg, o_zs_reg, o_sat_reg;

    logic signed [SB:0] d_full;
    logic [SB:0]        s_mag, d_mag;
    logic [OPND_W:0]    c_af, c_wf;
    logic [OPND_W-1:0]  ms_in, md_in;
    logic [WT_W:0]      wt_sum;
    logic [OPND_W-1:0]  wsum_mag, m2pos, m4pos, m3mag;
    logic [OPND_W-1:0]  v_sh;
    logic [RES_W-1:0]   v_comb;
    logic               v_sat;
    logic [SB-1:0]      mean_lim;
    logic [RES_W:0]     skew_lim;
    logic [RES_W+9:0]   kurt_q;
    logic signed [RES_W+9:0] kurt_s;
    logic [OPND_W:0]    acc_t;

    always_comb begin
        d_full = $signed({s_sample[SB-1], s_sample})
               - $signed({center_reg[SB-1], center_reg});
        s_mag  = s_sample[SB-1] ? (SB+1)'(-$signed({s_sample[SB-1], s_sample}))
                                : (SB+1)'($signed({s_sample[SB-1], s_sample}));
        d_mag  = d_full[SB] ? (SB+1)'(-d_full) : (SB+1)'(d_full);
        ms_in  = (OPND_W'(s_mag) << ACC_L) >> ACC_R;
        md_in  = (OPND_W'(d_mag) << ACC_L) >> ACC_R;
        wt_sum = {1'b0, wtot_reg} + (WT_W+1)'(s_weight);
        c_af   = clamp_mag(mul_p >> AF);
        c_wf   = clamp_mag(mul_p >> WF);
        wsum_mag = wsum_reg[OPND_W-1] ? OPND_W'(-wsum_reg) : OPND_W'(wsum_reg);
        m3mag    = mom3_reg[OPND_W-1] ? OPND_W'(-mom3_reg) : OPND_W'(mom3_reg);
        m2pos    = mom2_reg[OPND_W-1] ? '0 : OPND_W'(mom2_reg);
        m4pos    = mom4_reg[OPND_W-1] ? '0 : OPND_W'(mom4_reg);
        v_sh     = m2pos >> V_SH;
        v_sat    = v_sh[OPND_W-1:RES_W] != '0;
        v_comb   = v_sat ? '1 : v_sh[RES_W-1:0];
        mean_lim = (SB'(1) << (SB - 1)) - SB'(!wsum_reg[OPND_W-1]);
        skew_lim = {1'b0, 1'b0, {(RES_W-1){1'b1}}} + (RES_W+1)'(mom3_reg[OPND_W-1]);
        kurt_q   = (div_q > (PROD_W'(1) << 40)) ? (RES_W+10)'(1) << 40
                                                : div_q[RES_W+9:0];
        kurt_s   = $signed(kurt_q) - KURT_OFS;
        acc_t    = '0;
        case (state_reg)
            S_WS:    acc_t = sat_add(wsum_reg, signed_of(c_wf[OPND_W-1:0], ns_reg));
            S_T2:    acc_t = sat_add(mom2_reg, $signed(c_wf[OPND_W-1:0]));
            S_T3:    acc_t = sat_add(mom3_reg, signed_of(c_wf[OPND_W-1:0], nd_reg));
            S_T4:    acc_t = sat_add(mom4_reg, $signed(c_wf[OPND_W-1:0]));
            default: acc_t = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= S_IDLE;
            issued_reg     <= 1'b0;
            center_reg     <= '0;
            wtot_reg       <= '0;
            wsum_reg       <= '0;
            mom2_reg       <= '0;
            mom3_reg       <= '0;
            mom4_reg       <= '0;
            ovf_reg        <= 1'b0;
            rsat_reg       <= 1'b0;
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            mul_start_reg  <= 1'b0;
            div_start_reg  <= 1'b0;
            sqrt_start_reg <= 1'b0;
            if (m_valid_reg && m_ready && state_reg != S_DONE) m_valid_reg <= 1'b0;
            if (psel && penable && pwrite && paddr[2] == REG_CENTER) begin
                center_reg <= pwdata[SB-1:0];
            end
            case (state_reg)
                S_IDLE: begin
                    if (s_valid) begin
                        ms_reg   <= ms_in;
                        md_reg   <= md_in;
                        ns_reg   <= s_sample[SB-1];
                        nd_reg   <= d_full[SB];
                        w_reg    <= s_weight;
                        last_reg <= s_last;
                        if (wt_sum[WT_W]) begin
                            wtot_reg <= '1;
                            ovf_reg  <= 1'b1;
                        end else begin
                            wtot_reg <= wt_sum[WT_W-1:0];
                        end
                        issued_reg <= 1'b0;
                        state_reg  <= S_M2;
                    end
                end
                S_M2, S_M3, S_M4: begin
                    if (!issued_reg) begin
                        mul_a_reg     <= (state_reg == S_M2) ? md_reg :
                                         (state_reg == S_M3) ? m2_reg : m3_reg;
                        mul_b_reg     <= md_reg;
                        mul_start_reg <= 1'b1;
                        issued_reg    <= 1'b1;
                    end else if (mul_stat.done) begin
                        if (c_af[OPND_W]) ovf_reg <= 1'b1;
                        issued_reg <= 1'b0;
                        case (state_reg)
                            S_M2: begin
                                m2_reg    <= c_af[OPND_W-1:0];
                                state_reg <= S_M3;
                            end
                            S_M3: begin
                                m3_reg    <= c_af[OPND_W-1:0];
                                state_reg <= S_M4;
                            end
                            default: begin
                                m4_reg    <= c_af[OPND_W-1:0];
                                state_reg <= S_WS;
                            end
                        endcase
                    end
                end
                S_WS, S_T2, S_T3, S_T4: begin
                    if (!issued_reg) begin
                        mul_a_reg     <= (state_reg == S_WS) ? ms_reg :
                                         (state_reg == S_T2) ? m2_reg :
                                         (state_reg == S_T3) ? m3_reg : m4_reg;
                        mul_b_reg     <= OPND_W'(w_reg);
                        mul_start_reg <= 1'b1;
                        issued_reg    <= 1'b1;
                    end else if (mul_stat.done) begin
                        if (c_wf[OPND_W] || acc_t[OPND_W]) ovf_reg <= 1'b1;
                        issued_reg <= 1'b0;
                        case (state_reg)
                            S_WS: begin
                                wsum_reg  <= acc_t[OPND_W-1:0];
                                state_reg <= S_T2;
                            end
                            S_T2: begin
                                mom2_reg  <= acc_t[OPND_W-1:0];
                                state_reg <= S_T3;
                            end
                            S_T3: begin
                                mom3_reg  <= acc_t[OPND_W-1:0];
                                state_reg <= S_T4;
                            end
                            default: begin
                                mom4_reg  <= acc_t[OPND_W-1:0];
                                state_reg <= last_reg ? S_MEAN : S_IDLE;
                            end
                        endcase
                    end
                end
                S_MEAN: begin
                    if (!issued_reg) begin
                        zw_reg   <= wtot_reg == '0;
                        rsat_reg <= 1'b0;
                        if (wtot_reg == '0) begin
                            div_n_reg <= PROD_W'(wsum_mag) << NL_Z;
                            div_d_reg <= PROD_W'(1) << DL_Z;
                        end else begin
                            div_n_reg <= PROD_W'(wsum_mag) << NL_NZ;
                            div_d_reg <= PROD_W'(wtot_reg) << DL_NZ;
                        end
                        div_start_reg <= 1'b1;
                        issued_reg    <= 1'b1;
                    end else if (div_stat.done) begin
                        if (div_q > PROD_W'(mean_lim)) begin
                            rsat_reg <= 1'b1;
                            mean_reg <= wsum_reg[OPND_W-1] ? SB'(-mean_lim) : mean_lim;
                        end else begin
                            mean_reg <= wsum_reg[OPND_W-1] ? SB'(-div_q[SB-1:0])
                                                           : div_q[SB-1:0];
                        end
                        issued_reg <= 1'b0;
                        state_reg  <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (!issued_reg) begin
                        v_reg          <= v_comb;
                        if (v_sat) rsat_reg <= 1'b1;
                        sqrt_x_reg     <= OPND_W'(v_comb) << OUT_FRAC;
                        sqrt_start_reg <= 1'b1;
                        issued_reg     <= 1'b1;
                    end else if (sqrt_stat.done) begin
                        sd_reg     <= sqrt_r;
                        issued_reg <= 1'b0;
                        if (v_reg == '0) begin
                            skew_reg  <= '0;
                            kurt_reg  <= RES_W'(-KURT_OFS);
                            state_reg <= S_DONE;
                        end else begin
                            state_reg <= S_SKM;
                        end
                    end
                end
                S_SKM, S_KUM: begin
                    if (!issued_reg) begin
                        mul_a_reg     <= OPND_W'(v_reg);
                        mul_b_reg     <= (state_reg == S_SKM) ? OPND_W'(sd_reg)
                                                              : OPND_W'(v_reg);
                        mul_start_reg <= 1'b1;
                        issued_reg    <= 1'b1;
                    end else if (mul_stat.done) begin
                        div_d_reg  <= mul_p;
                        div_n_reg  <= (state_reg == S_SKM) ? PROD_W'(m3mag) << M_SH
                                                           : PROD_W'(m4pos) << M_SH;
                        issued_reg <= 1'b0;
                        state_reg  <= (state_reg == S_SKM) ? S_SKD : S_KUD;
                    end
                end
                S_SKD, S_KUD: begin
                    if (!issued_reg) begin
                        div_start_reg <= 1'b1;
                        issued_reg    <= 1'b1;
                    end else if (div_stat.done) begin
                        issued_reg <= 1'b0;
                        if (state_reg == S_SKD) begin
                            if (div_q > PROD_W'(skew_lim)) begin
                                rsat_reg <= 1'b1;
                                skew_reg <= mom3_reg[OPND_W-1] ? RES_W'(-skew_lim)
                                                               : skew_lim[RES_W-1:0];
                            end else begin
                                skew_reg <= mom3_reg[OPND_W-1] ? RES_W'(-div_q[RES_W-1:0])
                                                               : div_q[RES_W-1:0];
                            end
                            state_reg <= S_KUM;
                        end else begin
                            if (div_q > (PROD_W'(1) << 40) || kurt_s > KURT_TOP) begin
                                rsat_reg <= 1'b1;
                            end
                            if (kurt_s > KURT_TOP) begin
                                kurt_reg <= {1'b0, {(RES_W-1){1'b1}}};
                            end else begin
                                kurt_reg <= kurt_s[RES_W-1:0];
                            end
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_DONE: begin
                    if (!m_valid_reg || m_ready) begin
                        m_valid_reg <= 1'b1;
                        o_mean_reg  <= mean_reg;
                        o_var_reg   <= v_reg;
                        o_sd_reg    <= sd_reg;
                        o_skew_reg  <= skew_reg;
                        o_kurt_reg  <= kurt_reg;
                        o_zw_reg    <= zw_reg;
                        o_zs_reg    <= v_reg == '0;
                        o_sat_reg   <= ovf_reg || rsat_reg;
                        wtot_reg    <= '0;
                        wsum_reg    <= '0;
                        mom2_reg    <= '0;
                        mom3_reg    <= '0;
                        mom4_reg    <= '0;
                        ovf_reg     <= 1'b0;
                        state_reg   <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    wms_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .a       (mul_a_reg),
        .b       (mul_b_reg),
        .p       (mul_p),
        .stat    (mul_stat)
    );

    wms_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start_reg),
        .n       (div_n_reg),
        .d       (div_d_reg),
        .q       (div_q),
        .stat    (div_stat)
    );

    wms_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (sqrt_start_reg),
        .x       (sqrt_x_reg),
        .root    (sqrt_r),
        .stat    (sqrt_stat)
    );

    assign pready            = 1'b1;
    assign prdata            = (paddr[2] == REG_CENTER) ? 32'(center_reg) : '0;
    assign s_ready           = state_reg == S_IDLE;
    assign m_valid           = m_valid_reg;
    assign m_mean_out        = o_mean_reg;
    assign m_variance        = o_var_reg;
    assign m_std_dev         = o_sd_reg;
    assign m_skewness        = o_skew_reg;
    assign m_excess_kurtosis = o_kurt_reg;
    assign m_zero_weight_sum = o_zw_reg;
    assign m_zero_spread     = o_zs_reg;
    assign m_saturated       = o_sat_reg;
endmodule

// ----- rtl/wms_checker.sv -----
// ----------------------------------------------------------------------------
// wms_checker
// Port-level assertions for weighted_moment_statistics, bound to the top.
// ----------------------------------------------------------------------------
`include "weighted_moment_statistics_macros.svh"

module wms_checker #(
    parameter int SAMPLE_BITS = wms_pkg::SAMPLE_BITS_DEF
) (
    input logic                                aclk,
    input logic                                aresetn,
    input logic                                s_valid,
    input logic                                s_ready,
    input logic                                m_valid,
    input logic                                m_ready,
    input logic signed [SAMPLE_BITS-1:0]       m_mean_out,
    input logic [wms_pkg::RES_W-1:0]           m_variance,
    input logic [wms_pkg::RES_W-1:0]           m_std_dev,
    input logic signed [wms_pkg::RES_W-1:0]    m_skewness,
    input logic signed [wms_pkg::RES_W-1:0]    m_excess_kurtosis,
    input logic                                m_zero_spread
);
    import wms_pkg::*;

    localparam logic [RES_W-1:0] KURT_FLAT = RES_W'(-(64'sd3 <<< OUT_FRAC));

    // one item in flight
    `WMS_ASSERT_NEXT(a_busy_after_accept, s_valid && s_ready, !s_ready)
    // flat data set gives fixed shape figures
    `WMS_ASSERT_NOW(a_flat_shape, m_valid && m_zero_spread,
        m_std_dev == '0 && m_skewness == '0 && m_excess_kurtosis == KURT_FLAT)
    // zero_spread tracks the variance
    `WMS_ASSERT_NOW(a_spread_flag, m_valid, m_zero_spread == (m_variance == '0))
    // stalled result holds
    `WMS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready,
        m_valid && $stable(m_variance) && $stable(m_mean_out))
endmodule

bind weighted_moment_statistics wms_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_wms_checker (.*);

// ----- verif/weighted_moment_statistics_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// weighted_moment_statistics_test
// Sends runs of weighted samples, each closed by a last item, and checks every
// statistics result against a bit-true predictor of the moment accumulation,
// mean, variance, root, skewness and kurtosis. The center register is swept
// over its extremes between runs, and both channels stall at random.
// ----------------------------------------------------------------------------
module weighted_moment_statistics_test;
    import wms_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 600;
    localparam logic [63:0] MAG_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [39:0] WT_MAX  = 40'hFF_FFFF_FFFF;
    localparam logic signed [23:0] S_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] S_MIN = -24'sh800000;

    typedef struct {
        logic [23:0] mean_out;
        logic [31:0] variance;
        logic [31:0] std_dev;
        logic [31:0] skewness;
        logic [31:0] excess_kurtosis;
        logic        zero_weight_sum;
        logic        zero_spread;
        logic        saturated;
    } stats_t;

    logic aclk = 0;
    logic aresetn = 0;
    logic psel = 0, penable = 0, pwrite = 0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic pready;
    logic s_valid = 0;
    logic s_ready;
    logic signed [23:0] s_sample = '0;
    logic [16:0] s_weight = '0;
    logic s_last = 0;
    logic m_valid;
    logic m_ready = 0;
    logic signed [23:0] m_mean_out;
    logic [31:0] m_variance, m_std_dev;
    logic signed [31:0] m_skewness, m_excess_kurtosis;
    logic m_zero_weight_sum, m_zero_spread, m_saturated;

    weighted_moment_statistics uut (.*);

    initial begin
        forever #4 aclk = ~aclk;
    end

    // predictor state
    logic signed [23:0] center_q;
    logic [39:0]        wt_sum;
    logic signed [63:0] wx_sum, mom2, mom3, mom4;
    bit                 ovf, clip;

    stats_t expected_stats[$];
    int     mismatches = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;
    int     quiet_cycles = 0;

    function automatic logic [63:0] mag64(logic signed [63:0] v);
        return v[63] ? -v : v;
    endfunction

    function automatic logic [63:0] mul_trunc(logic [63:0] a, logic [63:0] b, int k);
        logic [127:0] p;
        p = ({64'b0, a} * {64'b0, b}) >> k;
        if (p > {64'b0, MAG_MAX}) begin
            ovf = 1;
            return MAG_MAX;
        end
        return p[63:0];
    endfunction

    function automatic logic [63:0] clamp(logic [127:0] x, logic [63:0] lim);
        if (x > {64'b0, lim}) begin
            clip = 1;
            return lim;
        end
        return x[63:0];
    endfunction

    function automatic logic signed [63:0] sat_add(logic signed [63:0] a,
                                                   logic signed [63:0] b);
        logic signed [64:0] r;
        r = {a[63], a} + {b[63], b};
        if (r > $signed({1'b0, MAG_MAX})) begin
            ovf = 1;
            return MAG_MAX;
        end
        if (r < -$signed({1'b0, MAG_MAX}) - 1) begin
            ovf = 1;
            return {1'b1, 63'b0};
        end
        return r[63:0];
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] x);
        logic [63:0] r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b = b >> 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic void clear_moments();
        wt_sum = 0; wx_sum = 0; mom2 = 0; mom3 = 0; mom4 = 0; ovf = 0;
    endfunction

    // accumulate one sample; on last, queue the statistics
    function automatic void accumulate_sample(logic signed [23:0] smp, logic [16:0] w,
                                              logic lst);
        logic signed [63:0] s, d, sk, ku;
        logic [63:0] ms, md, m2, m3, m4, mq, v, sd, q, num;
        logic [127:0] n, den;
        logic [40:0] wt_next;
        bit zw, zs, neg;
        stats_t r;
        s = smp;
        d = s - 64'(center_q);
        ms = mag64(s) << 17;
        md = mag64(d) << 17;
        m2 = mul_trunc(md, md, 40);
        m3 = mul_trunc(m2, md, 40);
        m4 = mul_trunc(m3, md, 40);
        wt_next = {1'b0, wt_sum} + w;
        if (wt_next > {1'b0, WT_MAX}) begin
            wt_sum = WT_MAX;
            ovf = 1;
        end else begin
            wt_sum = wt_next[39:0];
        end
        q = mul_trunc(ms, 64'(w), 16);
        wx_sum = sat_add(wx_sum, s < 0 ? -q : q);
        mom2 = sat_add(mom2, mul_trunc(m2, 64'(w), 16));
        q = mul_trunc(m3, 64'(w), 16);
        mom3 = sat_add(mom3, d < 0 ? -q : q);
        mom4 = sat_add(mom4, mul_trunc(m4, 64'(w), 16));
        if (!lst) return;

        clip = 0;
        zw = wt_sum == 0;
        neg = wx_sum < 0;
        n = {64'b0, mag64(wx_sum)};
        den = zw ? (128'd1 << 17) : ({88'b0, wt_sum} << 1);
        mq = clamp(n / den, neg ? 64'h80_0000 : 64'h7F_FFFF);
        r.mean_out = neg ? 24'(-mq) : mq[23:0];

        num = mom2 < 0 ? 64'd0 : mom2;
        v = clamp({64'b0, num >> 16}, 64'hFFFF_FFFF);
        sd = int_root(v << 24);
        zs = v == 0;
        if (zs) begin
            sk = 0;
            ku = -(64'sd3 <<< 24);
        end else begin
            neg = mom3 < 0;
            n = {64'b0, mag64(mom3)} << 32;
            q = clamp(n / {64'b0, v * sd}, neg ? 64'h8000_0000 : 64'h7FFF_FFFF);
            sk = neg ? -q : q;
            num = mom4 < 0 ? 64'd0 : mom4;
            n = {64'b0, num} << 32;
            q = clamp(n / ({64'b0, v} * {64'b0, v}), 64'd1 << 40);
            ku = $signed(q) - (64'sd3 <<< 24);
            if (ku > 64'sh7FFF_FFFF) begin
                ku = 64'sh7FFF_FFFF;
                clip = 1;
            end
        end
        r.variance = v[31:0];
        r.std_dev = sd[31:0];
        r.skewness = sk[31:0];
        r.excess_kurtosis = ku[31:0];
        r.zero_weight_sum = zw;
        r.zero_spread = zs;
        r.saturated = ovf | clip;
        expected_stats.push_back(r);
        clear_moments();
    endfunction

    task automatic send_sample(logic signed [23:0] smp, logic [16:0] w, logic lst);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1;
        s_sample <= smp;
        s_weight <= w;
        s_last <= lst;
        do @(posedge aclk); while (!s_ready);
        accumulate_sample(smp, w, lst);
    endtask

    task automatic wait_drained();
        s_valid <= 0;
        while (expected_stats.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_center(logic signed [23:0] c);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= ADDR_W'(4 * REG_CENTER);
        pwdata <= 32'(c);
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
        center_q = c;
    endtask

    function automatic logic signed [23:0] pick_sample();
        int k;
        k = $urandom_range(99);
        if (k < 8) return S_MAX;
        if (k < 16) return S_MIN;
        if (k < 20) return center_q;
        return 24'($urandom);
    endfunction

    function automatic logic [16:0] pick_weight();
        int k;
        k = $urandom_range(99);
        if (k < 8) return 0;
        if (k < 23) return 17'd65536;
        if (k < 40) return 17'($urandom_range(4095));
        return 17'($urandom_range(65535));
    endfunction

    // receiver backpressure
    always @(posedge aclk) begin
        m_ready <= $urandom_range(99) >= recv_idle_pct;
    end

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_stats.size() == 0) begin
                $error("unexpected result item");
                mismatches++;
            end else begin
                stats_t e;
                e = expected_stats.pop_front();
                if (m_mean_out !== e.mean_out) begin
                    $error("mean_out exp %h got %h", e.mean_out, m_mean_out); mismatches++;
                end
                if (m_variance !== e.variance) begin
                    $error("variance exp %h got %h", e.variance, m_variance); mismatches++;
                end
                if (m_std_dev !== e.std_dev) begin
                    $error("std_dev exp %h got %h", e.std_dev, m_std_dev); mismatches++;
                end
                if (m_skewness !== e.skewness) begin
                    $error("skewness exp %h got %h", e.skewness, m_skewness); mismatches++;
                end
                if (m_excess_kurtosis !== e.excess_kurtosis) begin
                    $error("excess_kurtosis exp %h got %h", e.excess_kurtosis,
                           m_excess_kurtosis);
                    mismatches++;
                end
                if (m_zero_weight_sum !== e.zero_weight_sum) begin
                    $error("zero_weight_sum exp %b got %b", e.zero_weight_sum,
                           m_zero_weight_sum);
                    mismatches++;
                end
                if (m_zero_spread !== e.zero_spread) begin
                    $error("zero_spread exp %b got %b", e.zero_spread, m_zero_spread);
                    mismatches++;
                end
                if (m_saturated !== e.saturated) begin
                    $error("saturated exp %b got %b", e.saturated, m_saturated);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (psel && penable))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles > WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_field_extremes();
        send_sample(S_MAX, 17'd65536, 1);
        send_sample(S_MIN, 17'd65536, 1);
        send_sample(24'sd1, 17'd1, 1);
        send_sample(S_MAX, 17'd32768, 0);
        send_sample(S_MIN, 17'd32768, 1);
        send_sample(24'sh2AAAAA, 17'h15555, 0);
        send_sample(-24'sh155556, 17'h0AAAA, 1);
        wait_drained();
    endtask

    task automatic test_zero_weight_sum();
        send_sample(S_MAX, 17'd0, 1);
        send_sample(24'sh123456, 17'd0, 0);
        send_sample(S_MIN, 17'd0, 1);
        send_sample(S_MAX, 17'd1, 1);
        wait_drained();
    endtask

    task automatic test_zero_spread();
        send_sample(24'sd0, 17'd65536, 1);
        send_sample(24'sd0, 17'd20000, 0);
        send_sample(24'sd0, 17'd45536, 1);
        wait_drained();
        write_center(S_MIN);
        send_sample(S_MIN, 17'd65536, 1);
        wait_drained();
    endtask

    task automatic test_center_extremes();
        send_sample(S_MAX, 17'd65536, 0);
        send_sample(S_MAX, 17'd65536, 1);
        send_sample(S_MIN, 17'd3, 1);
        wait_drained();
        write_center(S_MAX);
        send_sample(S_MIN, 17'd65536, 1);
        send_sample(24'sd0, 17'd100, 0);
        send_sample(S_MAX, 17'd65436, 1);
        wait_drained();
        write_center(24'sd0);
    endtask

    task automatic test_random(int n_items, int s_pct, int r_pct);
        int sent, len, k;
        logic signed [23:0] hi, lo;
        bit zero_w;
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        sent = 0;
        while (sent < n_items) begin
            k = $urandom_range(3);
            if (k == 0) write_center(S_MIN);
            else if (k == 1) write_center(S_MAX);
            else write_center(24'($urandom));
            for (int i = 0; i < 140; ) begin
                k = $urandom_range(99);
                zero_w = k < 5;
                if (k >= 96) begin
                    // long full-swing run drives the variance into saturation
                    len = $urandom_range(90, 66);
                    hi = center_q < 0 ? S_MAX : S_MIN;
                    for (int j = 0; j < len; j++)
                        send_sample(j[0] ? hi : 24'($urandom), 17'd65536, j == len - 1);
                end else begin
                    len = $urandom_range(8, 1);
                    for (int j = 0; j < len; j++) begin
                        lo = pick_sample();
                        send_sample(lo, zero_w ? 17'd0 : pick_weight(), j == len - 1);
                    end
                end
                i += len;
                sent += len;
            end
            wait_drained();
        end
    endtask

    initial begin
        clear_moments();
        center_q = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        test_field_extremes();
        test_zero_weight_sum();
        test_zero_spread();
        test_center_extremes();
        test_random(560, 37, 58);
        test_random(560, 58, 37);
        test_random(560, 0, 0);
        wait_drained();
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule
